// ----- rtl/dsp2_pkg.sv -----
// shared constants and types for the double power-of-two scaler
// used by dsp2_norm and double_scale_by_power_of_two
package dsp2_pkg;
    localparam int FracW = 52;
    localparam int ExpW  = 11;
    localparam int DataW = 64;
    localparam int ScaleW = 32;
    localparam int LzW   = 6;
    localparam int DefaultSlots = 2;

    localparam logic [ExpW-1:0] ExpAllOnes = 11'h7ff;

    // control carried alongside each item through the pipeline
    typedef struct packed {
        logic pass;        // nan, inf or zero: output equals input
        logic sgn;
    } dsp2_ctl_t;
endpackage

// ----- rtl/dsp2_norm.sv -----
// leading-zero count and left shift of a subnormal fraction, two registered stages
// depends on dsp2_pkg
module dsp2_norm (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [dsp2_pkg::FracW-1:0] frac_in,
    output logic [dsp2_pkg::LzW-1:0]   lz_out,
    output logic [dsp2_pkg::FracW:0]   man_out
);
    import dsp2_pkg::*;

    logic [FracW-1:0] frac_reg;
    logic [LzW-1:0]   lz_reg, lz_next;
    logic [LzW-1:0]   lz2_reg;
    logic [FracW:0]   man_reg;

    // count of zeros above the leading one, counted from bit 52
    always_comb begin
        lz_next = LzW'(FracW);
        for (int i = 0; i < FracW; i++) begin
            if (frac_in[i]) lz_next = LzW'(FracW - i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            frac_reg <= frac_in;
            lz_reg   <= lz_next;
            lz2_reg  <= lz_reg;
            man_reg  <= {1'b0, frac_reg} << lz_reg;
        end
    end

    // count is delayed so it lines up with the shifted significand
    assign lz_out  = lz2_reg;
    assign man_out = man_reg;
endmodule

// ----- rtl/double_scale_by_power_of_two.sv -----
// scales a raw binary64 pattern by two to a signed power
// one item per cycle sustained while the output is not stalled (m_tvalid high, m_tready low)
// a stall freezes all stages together; the output register is the last stage
// aresetn clears the stage valid bits only; no other state
// depends on dsp2_pkg and dsp2_norm
module double_scale_by_power_of_two (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // value_bits [63:0], scale [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // result_bits [63:0]
);
    import dsp2_pkg::*;

    localparam int NV = DefaultSlots + 2;
    localparam int SumW = 34;

    logic [NV-1:0] vld_reg;
    logic          en;

    assign en       = !vld_reg[NV-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NV-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[NV-2:0], s_tvalid};
    end

    // stage 1: decode
    logic [DataW-1:0] s_val;
    logic [ExpW-1:0]  s_exp;
    assign s_val = s_tdata[63:0];
    assign s_exp = s_val[62:52];

    dsp2_ctl_t        c1_reg, c2_reg, c3_reg;
    logic [DataW-1:0] v1_reg, v2_reg, v3_reg;
    logic             sub1_reg, sub2_reg;
    logic [ExpW-1:0]  e1_reg, e2_reg;
    logic signed [ScaleW-1:0] p1_reg, p2_reg;
    logic [FracW-1:0] f1_reg, f2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg.pass <= (s_exp == ExpAllOnes) || (s_val[62:0] == '0);
            c1_reg.sgn  <= s_val[63];
            v1_reg      <= s_val;
            sub1_reg    <= (s_exp == '0);
            e1_reg      <= s_exp;
            p1_reg      <= s_tdata[95:64];
            f1_reg      <= s_val[FracW-1:0];
            c2_reg <= c1_reg; v2_reg <= v1_reg; sub2_reg <= sub1_reg;
            e2_reg <= e1_reg; p2_reg <= p1_reg; f2_reg <= f1_reg;
        end
    end

    logic [LzW-1:0] lz;
    logic [FracW:0] nman;
    dsp2_norm u_norm (
        .aclk(aclk), .en(en), .frac_in(s_val[FracW-1:0]),
        .lz_out(lz), .man_out(nman)
    );

    // stage 3: new exponent and significand
    logic signed [SumW-1:0] ne_next, ne_reg;
    logic [FracW:0]         m_next, m3_reg;
    always_comb begin
        if (sub2_reg) begin
            ne_next = SumW'(1) - SumW'(lz) + SumW'(p2_reg);
            m_next  = nman;
        end else begin
            ne_next = SumW'(e2_reg) + SumW'(p2_reg);
            m_next  = {1'b1, f2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_reg <= c2_reg; v3_reg <= v2_reg;
            ne_reg <= ne_next; m3_reg <= m_next;
        end
    end

    // stage 4: pack
    logic [DataW-1:0] r_next, r_reg;
    logic [SumW-1:0]  sh;
    always_comb begin
        sh = SumW'(1) - ne_reg;
        if (c3_reg.pass) r_next = v3_reg;
        else if (ne_reg >= SumW'(2047)) r_next = {c3_reg.sgn, ExpAllOnes, 52'd0};
        else if (ne_reg <= -SumW'(52))  r_next = {c3_reg.sgn, 63'd0};
        else if (ne_reg <= 0)
            r_next = {c3_reg.sgn, 10'd0, m3_reg >> sh[5:0]};
        else r_next = {c3_reg.sgn, ne_reg[10:0], m3_reg[FracW-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (en) r_reg <= r_next;
    end
    assign m_tdata = r_reg;
endmodule

// ----- bench/testbench.sv -----
// self-checking bench for double_scale_by_power_of_two
// computes the expected binary64 pattern of each item; needs rtl/dsp2_pkg.sv and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandItems = 1650;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // value_bits [63:0], scale [95:64]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // result_bits [63:0]

    logic [95:0] pending_items[$];
    logic [63:0] scaled_expected[$];
    int          fail_count = 0;
    int          checked_count = 0;
    bit          stim_done = 1'b0;
    bit          no_idle = 1'b0;

    double_scale_by_power_of_two u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] scale_double(logic [63:0] bits, logic signed [31:0] power);
        logic [63:0]        sgn;
        logic signed [63:0] ex;
        logic [63:0]        man;
        logic signed [63:0] ne;
        sgn = bits & 64'h8000000000000000;
        ex  = $signed({53'd0, bits[62:52]});
        man = {12'd0, bits[51:0]};
        if (bits[62:52] == dsp2_pkg::ExpAllOnes) return bits;
        if (bits[62:52] == '0) begin
            if (man == 0) return bits;
            ex = 1;
            for (int k = 0; k < 52 && man[52] == 1'b0; k++) begin
                man = man << 1;
                ex = ex - 1;
            end
            man = man & 64'h000fffffffffffff;
        end
        ne = ex + 64'(power);
        if (ne >= 2047) return sgn | (64'h7ff << 52);
        if (ne <= 0) begin
            if (ne <= -52) return sgn;
            man = (man | (64'd1 << 52)) >> (1 - ne);
            return sgn | man;
        end
        return sgn | (64'(ne) << 52) | man;
    endfunction

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        int          pick;
        v = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        // bias toward subnormals, specials and zero fractions
        if (pick == 0) v[62:52] = '0;
        else if (pick == 1) v[62:52] = 11'h7ff;
        else if (pick == 2) v[51:0] = '0;
        else if (pick == 3) begin
            v[62:52] = '0;
            v[51:0] = 52'd1 << $urandom_range(0, 51);
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_scale(logic [63:0] v);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return $urandom;
        if (pick == 2) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        if (pick < 6) return 32'($urandom_range(0, 200)) - 32'd100;
        // land near the overflow or underflow edge
        if (pick < 8) return 32'(2046 + $urandom_range(0, 4)) - 32'(v[62:52]);
        return 32'(-$urandom_range(0, 56)) - 32'(v[62:52]);
    endfunction

    function automatic void add_item(logic [63:0] v, logic [31:0] sc);
        pending_items.push_back({sc, v});
    endfunction

    initial begin
        add_item(64'h0000000000000000, 32'd5);
        add_item(64'h8000000000000000, 32'h80000000);
        add_item(64'h7ff0000000000000, 32'd1);
        add_item(64'hfff0000000000000, 32'hffffffff);
        add_item(64'h7ff8000000000123, 32'd3);
        add_item(64'hfff0000000000001, 32'h7fffffff);
        add_item(64'h0000000000000001, 32'd0);
        add_item(64'h0000000000000001, 32'd52);
        add_item(64'h800fffffffffffff, 32'd1);
        add_item(64'h000fffffffffffff, 32'hffffffff);
        add_item(64'h3ff0000000000000, 32'd1023);
        add_item(64'h3ff0000000000000, 32'd1024);
        add_item(64'h3ff0000000000000, 32'hfffffc02);
        add_item(64'hbfffffffffffffff, 32'hfffffbce);
        add_item(64'h3ff0000000000000, 32'hfffffbcd);
        add_item(64'h3ff0000000000000, 32'hfffffbcc);
        add_item(64'h7fefffffffffffff, 32'd1);
        add_item(64'h7fefffffffffffff, 32'h7fffffff);
        add_item(64'h0010000000000000, 32'h80000000);
        add_item(64'hffffffffffffffff, 32'd0);
        add_item(64'hffefffffffffffff, 32'hffffffff);
        add_item(64'h0000000000000001, 32'hffffffff);
        for (int i = 0; i < RandItems; i++) begin
            logic [63:0] v;
            v = rand_double();
            add_item(v, rand_scale(v));
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // window with no idling on either side
    always @(posedge aclk) begin
        no_idle <= (checked_count > 600 && checked_count < 900);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= 11)) begin
                    logic [95:0] it;
                    it = pending_items.pop_front();
                    s_tdata <= it;
                    s_tvalid <= 1'b1;
                    scaled_expected.push_back(scale_double(it[63:0], it[95:64]));
                end else begin
                    s_tvalid <= 1'b0;
                    if (pending_items.size() == 0) stim_done <= 1'b1;
                end
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (scaled_expected.size() == 0) begin
                $display("%t unexpected result: expected none, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                logic [63:0] want;
                want = scaled_expected.pop_front();
                if (m_tdata !== want) begin
                    $display("%t result_bits mismatch: expected %h, actual %h",
                             $time, want, m_tdata);
                    fail_count++;
                end
                checked_count++;
            end
        end
    end

    initial begin
        wait (aresetn);
        wait (stim_done && scaled_expected.size() == 0);
        repeat (20) @(posedge aclk);
        $display("checked %0d scaled results, directed edge cases and random operands",
                 checked_count);
        if (fail_count == 0 && scaled_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #500us;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/dsp2_pkg.sv
rtl/dsp2_norm.sv
rtl/double_scale_by_power_of_two.sv
bench/testbench.sv
